// ===== rtl/luhn_pkg.sv =====
// ----------------------------------------------------------------------------
// luhn_pkg: shared types and constants for the card number check
// Holds field widths, brand codes and the control and status structs that
// pass between the top level and the conversion and scan units.
// ----------------------------------------------------------------------------
package luhn_pkg;

	localparam int CARD_W    = 64;  // card number width
	localparam int BIT_CNT_W = 6;   // counts the binary bits of one card number
	localparam int DCNT_W    = 5;   // holds a digit index or a digit count (up to 20)

	localparam logic [1:0] BRAND_NONE  = 2'd0;
	localparam logic [1:0] BRAND_AM    = 2'd1;  // prefix 34/37, 15 digits
	localparam logic [1:0] BRAND_MC    = 2'd2;  // prefix 51..55, 16 digits
	localparam logic [1:0] BRAND_FOUR  = 2'd3;  // prefix 4x, 13 or 16 digits

	typedef struct packed {
		logic load;    // take a new card number, clear the BCD register
		logic dabble;  // one binary-to-BCD shift step
		logic dshift;  // shift the BCD register down by one digit
	} conv_ctrl_t;

	typedef struct packed {
		logic start;   // clear the accumulators
		logic step;    // consume one digit
	} scan_ctrl_t;

	typedef struct packed {
		logic              last;     // the digit being consumed is the top slot
		logic [3:0]        sum_mod;  // weighted sum modulo 10
		logic [DCNT_W-1:0] ndig;     // digit count up to the highest nonzero digit
		logic [3:0]        lead_d;   // most significant nonzero digit
		logic [3:0]        next_d;   // digit just below it
	} scan_stat_t;

endpackage

// ===== rtl/card_number_luhn_brand_check.sv =====
// ----------------------------------------------------------------------------
// card_number_luhn_brand_check: Luhn checksum and brand classification
// Converts a binary card number to decimal one bit per cycle, scans the
// digits one per cycle for the mod-10 sum, then classifies the brand.
// ----------------------------------------------------------------------------
//
//   channel | signals                          | beat carries
//   --------+----------------------------------+----------------------------
//   in      | in_valid, in_ready, card_value   | one card number (64 b)
//   out     | out_valid, out_ready,            | brand code (2 b), pass (1 b)
//           | brand_code, luhn_pass            |
//
// Each item passes through the conversion (one step per binary bit through the
// shift-add-3 converter), the scan (one step per decimal digit slot through
// the accumulator) and the load of the output register. Ready rises with the
// result, so the block works on one card number at a time. A new card
// number is taken once the previous one has reached the output register,
// even while that result waits. Reset clears the sequencer and the output
// valid; no memory needs clearing.
// A stalled output holds the finished result in the scan unit until the
// output register frees up.
// ----------------------------------------------------------------------------
module card_number_luhn_brand_check #(
	parameter int MAX_DIGITS = 19
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [luhn_pkg::CARD_W-1:0] card_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  brand_code,
	output logic                        luhn_pass
);
	import luhn_pkg::*;

	// one spare slot catches numbers with one digit too many
	localparam int NDIG = MAX_DIGITS + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic                 out_valid_q;
	logic [1:0]           brand_q;
	logic                 pass_q;

	conv_ctrl_t conv_ctrl;
	scan_ctrl_t scan_ctrl;
	scan_stat_t stat;
	logic [3:0] digit;
	logic       ovf;
	logic       in_beat;
	logic       out_load;
	logic       pass_nx;
	logic [1:0] brand_nx;

	assign in_ready = (state_q == ST_IDLE);
	assign in_beat  = in_valid && in_ready;
	// move the finished result into the output register once it is free
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign conv_ctrl.load   = in_beat;
	assign conv_ctrl.dabble = (state_q == ST_CONV);
	assign conv_ctrl.dshift = (state_q == ST_SCAN);
	assign scan_ctrl.start  = in_beat;
	assign scan_ctrl.step   = (state_q == ST_SCAN);

	luhn_bcd_conv #(
		.NDIG(NDIG)
	) u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (conv_ctrl),
		.card_value(card_value),
		.digit     (digit),
		.ovf       (ovf)
	);

	luhn_digit_scan #(
		.NDIG(NDIG)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (scan_ctrl),
		.digit (digit),
		.stat  (stat)
	);

	// Pass needs a zero sum, no overflow past the slots and a count in range.
	// Brand needs a pass and at least two digits for a prefix.
	always_comb begin
		pass_nx  = (stat.sum_mod == 4'd0) && !ovf &&
		           (stat.ndig <= DCNT_W'(MAX_DIGITS));
		brand_nx = BRAND_NONE;
		if (pass_nx && (stat.ndig >= DCNT_W'(2))) begin
			if (stat.lead_d == 4'd3 && (stat.next_d == 4'd4 || stat.next_d == 4'd7) &&
			    stat.ndig == DCNT_W'(15)) begin
				brand_nx = BRAND_AM;
			end else if (stat.lead_d == 4'd5 && stat.next_d inside {[4'd1:4'd5]} &&
			             stat.ndig == DCNT_W'(16)) begin
				brand_nx = BRAND_MC;
			end else if (stat.lead_d == 4'd4 &&
			             (stat.ndig == DCNT_W'(13) || stat.ndig == DCNT_W'(16))) begin
				brand_nx = BRAND_FOUR;
			end
		end
	end

	// sequencer and output register; the result payload holds until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			brand_q     <= BRAND_NONE;
			pass_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						bit_cnt_q <= '0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
					if (bit_cnt_q == BIT_CNT_W'(CARD_W - 1)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
				brand_q     <= brand_nx;
				pass_q      <= pass_nx;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign brand_code = brand_q;
	assign luhn_pass  = pass_q;

endmodule

// ===== rtl/luhn_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// luhn_bcd_conv: bit-serial binary to BCD converter
// Shift-add-3 over one bit per cycle, then hands the digits out one per
// cycle from the least significant end. Flags a value too wide for the slots.
// ----------------------------------------------------------------------------
module luhn_bcd_conv #(
	parameter int NDIG = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  luhn_pkg::conv_ctrl_t       ctrl,
	input  logic [luhn_pkg::CARD_W-1:0] card_value,
	output logic [3:0]                 digit,
	output logic                       ovf
);
	import luhn_pkg::*;

	localparam int BCD_W = 4 * NDIG;

	logic [CARD_W-1:0] bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  adj;
	logic              ovf_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		logic [3:0] d;
		adj = '0;
		for (int k = 0; k < NDIG; k++) begin
			d = bcd_q[4*k +: 4];
			adj[4*k +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			bcd_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctrl.load) begin
			bin_q <= card_value;
			bcd_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctrl.dabble) begin
			bin_q <= {bin_q[CARD_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[CARD_W-1]};
			ovf_q <= ovf_q | adj[BCD_W-1];
		end else if (ctrl.dshift) begin
			bcd_q <= {4'd0, bcd_q[BCD_W-1:4]};
		end
	end

	assign digit = bcd_q[3:0];
	assign ovf   = ovf_q;

endmodule

// ===== rtl/luhn_digit_scan.sv =====
// ----------------------------------------------------------------------------
// luhn_digit_scan: one-digit-per-cycle Luhn accumulator
// Folds each digit into the weighted sum modulo 10 and tracks the digit
// count and the two leading digits.
// ----------------------------------------------------------------------------
module luhn_digit_scan #(
	parameter int NDIG = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  luhn_pkg::scan_ctrl_t  ctrl,
	input  logic [3:0]            digit,
	output luhn_pkg::scan_stat_t  stat
);
	import luhn_pkg::*;

	logic [DCNT_W-1:0] idx_q;
	logic [3:0]        acc_q;
	logic [DCNT_W-1:0] ndig_q;
	logic [3:0]        lead_q;
	logic [3:0]        next_q;
	logic [3:0]        prev_q;

	logic [4:0] dbl;
	logic [3:0] wd;
	logic [4:0] sum;
	logic [3:0] acc_nx;

	// double odd positions, fold a two-digit result back to one digit
	always_comb begin
		dbl = {digit, 1'b0};
		if (dbl > 5'd9) begin
			dbl = dbl - 5'd9;
		end
		wd  = idx_q[0] ? dbl[3:0] : digit;
		sum = {1'b0, acc_q} + {1'b0, wd};
		acc_nx = (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctrl.start) begin
			idx_q <= '0;
		end else if (ctrl.step) begin
			idx_q <= idx_q + DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			acc_q  <= '0;
			ndig_q <= '0;
			lead_q <= '0;
			next_q <= '0;
			prev_q <= '0;
		end else if (ctrl.step) begin
			acc_q  <= acc_nx;
			prev_q <= digit;
			if (digit != 4'd0) begin
				ndig_q <= idx_q + DCNT_W'(1);
				lead_q <= digit;
				next_q <= prev_q;
			end
		end
	end

	assign stat.last    = (idx_q == DCNT_W'(NDIG - 1));
	assign stat.sum_mod = acc_q;
	assign stat.ndig    = ndig_q;
	assign stat.lead_d  = lead_q;
	assign stat.next_d  = next_q;

endmodule

// ===== rtl/luhn_checker.sv =====
// ----------------------------------------------------------------------------
// luhn_checker: port-level checks for the card number check
// Watches the handshakes and result fields of the top level over time.
// ----------------------------------------------------------------------------
module luhn_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [luhn_pkg::CARD_W-1:0] card_value,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [1:0]                  brand_code,
	input logic                        luhn_pass
);
	import luhn_pkg::*;

	// an offered card number holds until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(card_value))
		else $error("input beat changed while waiting");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(brand_code) && $stable(luhn_pass))
		else $error("result beat changed while stalled");

	// a brand is only given to a number that passes
	a_brand_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (brand_code != BRAND_NONE) |-> luhn_pass)
		else $error("brand reported without a passing checksum");

	// one number at a time: ready drops right after an input beat
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a number is in work");

	// a fresh result leaves the block ready for the next number
	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while the block is still busy");

endmodule

bind card_number_luhn_brand_check luhn_checker u_luhn_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for card_number_luhn_brand_check
// Drives card numbers through the valid/ready input channel and checks each
// brand and checksum verdict against a local mod-10 and prefix predictor.
// The sender works in bursts and the receiver stalls on its own schedule.
// ----------------------------------------------------------------------------
module tb;
	import luhn_pkg::*;

	localparam int MAX_DIGITS   = 19;
	localparam int RANDOM_CARDS = 850;
	localparam int TAIL_CYCLES  = 200;            // well past one item's latency
	localparam int MAX_PRINTS   = 50;
	localparam longint LIMIT_NS = 64'd2_000_000;  // overall time limit in ns

	// receiver stall modes
	localparam int RX_READY      = 0;
	localparam int RX_CHOPPY     = 1;
	localparam int RX_LONG_STALL = 2;

	typedef struct packed {
		logic [1:0] brand;
		logic       pass;
	} verdict_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [CARD_W-1:0]   card_value = '0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [1:0]          brand_code;
	logic                luhn_pass;

	verdict_t expected_verdicts[$];
	int       cards_sent    = 0;
	int       verdicts_seen = 0;
	int       error_count   = 0;
	int       brand_seen[4] = '{0, 0, 0, 0};
	int       pass_seen     = 0;

	// sender burst control
	bit       idle_off   = 1'b0;
	int       burst_left = 0;

	// receiver stall schedule
	int       rx_mode    = RX_READY;
	int       stall_left = 0;
	int       rx_cycle   = 0;

	card_number_luhn_brand_check #(
		.MAX_DIGITS(MAX_DIGITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.card_value(card_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.brand_code(brand_code),
		.luhn_pass (luhn_pass)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard stop: catches a hung handshake or a result that never shows up.
	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Weighted decimal digit sum: every digit at an odd position counted from
	// the least significant one is doubled, and a doubled value above nine
	// folds back to the sum of its two digits.
	function automatic int unsigned luhn_sum(input logic [CARD_W-1:0] card);
		logic [CARD_W-1:0] rest;
		int unsigned       d;
		int unsigned       s;
		int unsigned       pos;
		rest = card;
		s    = 0;
		pos  = 0;
		while (rest != 0) begin
			d = 32'(rest % 10);
			if (pos[0]) begin
				d = d * 2;
				if (d > 9)
					d = d - 9;
			end
			s    += d;
			rest  = rest / 10;
			pos++;
		end
		return s;
	endfunction

	// Full verdict for one card number. A number with more digits than the
	// block takes fails outright; a brand needs a passing checksum, at least
	// two digits, and a prefix and length that match one of the brand rules.
	function automatic verdict_t predict_verdict(input logic [CARD_W-1:0] card);
		logic [CARD_W-1:0] rest;
		logic [3:0]        lead;
		logic [3:0]        nxt;
		int unsigned       ndig;
		int unsigned       prefix;
		verdict_t          v;
		rest = card;
		lead = '0;
		nxt  = '0;
		ndig = 0;
		while (rest != 0) begin
			nxt  = lead;
			lead = 4'(rest % 10);
			rest = rest / 10;
			ndig++;
		end
		v.pass  = (luhn_sum(card) % 10 == 0) && (ndig <= MAX_DIGITS);
		v.brand = BRAND_NONE;
		prefix  = 32'(lead) * 10 + 32'(nxt);
		if (v.pass && ndig >= 2) begin
			if ((prefix == 34 || prefix == 37) && ndig == 15)
				v.brand = BRAND_AM;
			else if (prefix >= 51 && prefix <= 55 && ndig == 16)
				v.brand = BRAND_MC;
			else if (prefix >= 40 && prefix <= 49 && (ndig == 13 || ndig == 16))
				v.brand = BRAND_FOUR;
		end
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Build a checksum-valid number: two-digit prefix, random body, and a
	// final check digit chosen so the weighted sum lands on a multiple of ten.
	function automatic logic [CARD_W-1:0] make_card(input int unsigned prefix,
			input int unsigned ndig);
		logic [CARD_W-1:0] v;
		int unsigned       i;
		int unsigned       s;
		v = 64'(prefix);
		for (i = 2; i < ndig - 1; i++)
			v = v * 10 + $urandom_range(0, 9);
		v = v * 10;
		s = luhn_sum(v);
		v = v + (10 - s % 10) % 10;
		return v;
	endfunction

	// Random number with exactly ndig decimal digits.
	function automatic logic [CARD_W-1:0] random_decimal(input int unsigned ndig);
		logic [CARD_W-1:0] v;
		int unsigned       i;
		v = 64'($urandom_range(1, 9));
		for (i = 1; i < ndig; i++)
			v = v * 10 + $urandom_range(0, 9);
		return v;
	endfunction

	// Nudge the last digit so the checksum no longer closes.
	function automatic logic [CARD_W-1:0] break_check(input logic [CARD_W-1:0] v);
		return (v % 10 == 9) ? v - 1 : v + 1;
	endfunction

	// Send one card number as one input beat. Between bursts, drop valid for
	// a random gap; within a burst, hold valid high straight into the next beat.
	task automatic send_card(input logic [CARD_W-1:0] v);
		int unsigned gap;
		if (!idle_off && burst_left == 0) begin
			gap = $urandom_range(1, 40);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		card_value <= v;
		do
			@(posedge clk);
		while (!in_ready);
		expected_verdicts.push_back(predict_verdict(v));
		cards_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// Hold off the sender until every outstanding verdict has come back.
	task automatic wait_for_verdicts();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTS)
			$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Zero, single digits, the two-digit minimum, the largest accepted number
	// and numbers with one digit too many, plus top-bit patterns.
	task automatic test_special_cases();
		send_card(64'd0);
		send_card(64'd1);
		send_card(64'd9);
		send_card(64'd18);                          // two digits, checksum closes
		send_card(64'd10);
		send_card(64'd9999999999999999999);         // largest 19-digit value
		send_card(64'd10000000000000000000);        // smallest 20-digit value
		send_card(64'hFFFF_FFFF_FFFF_FFFF);         // all ones, 20 digits
		send_card(64'h8000_0000_0000_0000);         // top bit alone, 19 digits
	endtask

	// Each brand at its edges, and numbers that miss by prefix, by length
	// or by checksum.
	task automatic test_brand_rules();
		send_card(make_card(34, 15));
		send_card(make_card(37, 15));
		send_card(make_card(51, 16));
		send_card(make_card(55, 16));
		send_card(make_card(40, 13));
		send_card(make_card(49, 16));
		send_card(make_card(40, 16));
		send_card(make_card(34, 16));               // right prefix, wrong length
		send_card(make_card(50, 16));               // just below the 51..55 band
		send_card(make_card(56, 16));               // just above it
		send_card(make_card(45, 14));               // 4x with neither 13 nor 16
		send_card(break_check(make_card(37, 15)));  // brand shape, bad checksum
		send_card(make_card(33, 15));
	endtask

	// Mostly well-formed brand candidates with random bodies, mixed with
	// random lengths, small values, near-maximum and full-width noise.
	task automatic test_random_cards();
		logic [CARD_W-1:0] v;
		int unsigned       pick;
		int                n;
		for (n = 0; n < RANDOM_CARDS; n++) begin
			// run one stretch with no sender gaps, and drain once midway
			idle_off = (n >= 300 && n < 420);
			if (n == 425)
				wait_for_verdicts();
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				case ($urandom_range(0, 3))
					0: v = make_card($urandom_range(0, 1) ? 34 : 37, 15);
					1: v = make_card($urandom_range(51, 55), 16);
					2: v = make_card($urandom_range(40, 49), $urandom_range(0, 1) ? 13 : 16);
					default: v = make_card($urandom_range(10, 99), $urandom_range(12, 17));
				endcase
				if ($urandom_range(0, 4) == 0)
					v = break_check(v);
			end else if (pick < 75) begin
				v = random_decimal($urandom_range(1, MAX_DIGITS));
			end else if (pick < 87) begin
				v = 64'($urandom_range(0, 999));
			end else if (pick < 95) begin
				// 19 digits reaching past 2**63, so the top bit toggles
				v = 64'd9000000000000000000 + {$urandom, $urandom} % 64'd1000000000000000000;
			end else begin
				v = {$urandom, $urandom};
			end
			send_card(v);
		end
		idle_off = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Receiver: stall schedule with a randomly chosen mode
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 1500 == 0)
			rx_mode = $urandom_range(RX_READY, RX_LONG_STALL);
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_READY: begin
					out_ready <= 1'b1;
				end
				RX_CHOPPY: begin
					out_ready <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					// hold ready low for a long stretch now and then
					if ($urandom_range(0, 15) == 0) begin
						stall_left = $urandom_range(1, 120);
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Checker: compare each output beat with the oldest expected verdict
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			verdicts_seen++;
			if (expected_verdicts.size() == 0) begin
				report_mismatch($sformatf("verdict brand=%0d pass=%0b with none expected",
					brand_code, luhn_pass));
			end else begin
				want = expected_verdicts.pop_front();
				if (brand_code !== want.brand)
					report_mismatch($sformatf("brand_code %0d, expected %0d",
						brand_code, want.brand));
				if (luhn_pass !== want.pass)
					report_mismatch($sformatf("luhn_pass %0b, expected %0b",
						luhn_pass, want.pass));
				brand_seen[want.brand]++;
				if (want.pass)
					pass_seen++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		// hold reset, then release it away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_special_cases();
		test_brand_rules();
		test_random_cards();

		// drop valid, drain, then let the pipeline settle
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d card numbers, checked %0d verdicts, %0d mismatches",
			cards_sent, verdicts_seen, error_count);
		$display("Verdicts by brand none/34-37/51-55/4x: %0d/%0d/%0d/%0d, checksum passes: %0d",
			brand_seen[0], brand_seen[1], brand_seen[2], brand_seen[3], pass_seen);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/luhn_pkg.sv
rtl/luhn_bcd_conv.sv
rtl/luhn_digit_scan.sv
rtl/card_number_luhn_brand_check.sv
rtl/luhn_checker.sv
dv/tb.sv
